>>> sv/spmq_pkg.sv
package spmq_pkg;

  localparam int LEVELS = 3;
  localparam int DEPTH  = 16;

  localparam int LEVEL_W = 3;
  localparam int VALUE_W = 16;
  localparam int STATUS_W = 2;

  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (LEVELS * DEPTH > 1) ? $clog2(LEVELS * DEPTH) : 1;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

>>> sv/spmq_if.sv
interface spmq_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [spmq_pkg::LEVEL_W-1:0]   level;
  logic [spmq_pkg::VALUE_W-1:0]   item_value;

  modport source (output valid, action, level, item_value, input ready);
  modport sink (input valid, action, level, item_value, output ready);
endinterface

interface spmq_out_if;
  logic                           valid;
  logic                           ready;
  logic [spmq_pkg::STATUS_W-1:0]  status;
  logic [spmq_pkg::VALUE_W-1:0]   out_value;
  logic                           all_empty;

  modport source (output valid, status, out_value, all_empty, input ready);
  modport sink (input valid, status, out_value, all_empty, output ready);
endinterface

>>> sv/strict_priority_multi_queue_top.sv
// A result passes the s1 stage and the output register after acceptance; one
// transaction per cycle unless the output stalls. Level pointers and counts
// update at acceptance; the entry memory is read through a registered port.
// Reset (synchronous, active high) clears all pointers, counts and valid flags;
// the entry memory keeps its contents and is never read before it is written.
module strict_priority_multi_queue_top (
  input logic         clk,
  input logic         rst,
  spmq_in_if.sink     in_ch,
  spmq_out_if.source  out_ch
);

  logic [spmq_pkg::PTR_W-1:0]   head [spmq_pkg::LEVELS];
  logic [spmq_pkg::PTR_W-1:0]   tail [spmq_pkg::LEVELS];
  logic [spmq_pkg::CNT_W-1:0]   count [spmq_pkg::LEVELS];
  logic [spmq_pkg::PTR_W-1:0]   head_next [spmq_pkg::LEVELS];
  logic [spmq_pkg::PTR_W-1:0]   tail_next [spmq_pkg::LEVELS];
  logic [spmq_pkg::CNT_W-1:0]   count_next [spmq_pkg::LEVELS];

  logic [spmq_pkg::VALUE_W-1:0] mem [spmq_pkg::LEVELS * spmq_pkg::DEPTH];
  logic [spmq_pkg::VALUE_W-1:0] rdata;
  logic [spmq_pkg::ADDR_W-1:0]  wr_addr;
  logic [spmq_pkg::ADDR_W-1:0]  rd_addr;
  logic                         wr_en;
  logic                         take;

  logic [spmq_pkg::LVL_W-1:0]   lvl;
  logic [spmq_pkg::LVL_W-1:0]   sel;
  logic                         hit;
  logic [spmq_pkg::STATUS_W-1:0] status_new;
  logic                         empty_new;

  logic                         s1_valid;
  logic [spmq_pkg::STATUS_W-1:0] s1_status;
  logic                         s1_take;
  logic                         s1_empty;
  logic                         s1_move;
  logic                         accept;

  logic                         out_valid;
  logic [spmq_pkg::STATUS_W-1:0] out_status;
  logic [spmq_pkg::VALUE_W-1:0] out_value;
  logic                         out_empty;

  assign s1_move     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_move;
  assign accept      = in_ch.valid && in_ch.ready;
  assign lvl         = in_ch.level[spmq_pkg::LVL_W-1:0];

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    status_new = spmq_pkg::ST_OK;
    wr_en      = 1'b0;
    take       = 1'b0;
    wr_addr    = '0;
    rd_addr    = '0;
    hit        = 1'b0;
    sel        = '0;
    for (int k = spmq_pkg::LEVELS - 1; k >= 0; k--) begin
      if (count[k] != '0) begin
        hit = 1'b1;
        sel = spmq_pkg::LVL_W'(k);
      end
    end
    if (in_ch.action == spmq_pkg::ACT_INSERT) begin
      if ({1'b0, in_ch.level} >= 4'(spmq_pkg::LEVELS)) begin
        status_new = spmq_pkg::ST_RANGE;
      end else if (count[lvl] == spmq_pkg::CNT_W'(spmq_pkg::DEPTH)) begin
        status_new = spmq_pkg::ST_FULL;
      end else begin
        wr_en   = 1'b1;
        wr_addr = spmq_pkg::ADDR_W'(lvl) * spmq_pkg::ADDR_W'(spmq_pkg::DEPTH)
                  + spmq_pkg::ADDR_W'(tail[lvl]);
        tail_next[lvl]  = (tail[lvl] == spmq_pkg::PTR_W'(spmq_pkg::DEPTH - 1)) ?
                          '0 : tail[lvl] + 1'b1;
        count_next[lvl] = count[lvl] + 1'b1;
      end
    end else if (!hit) begin
      status_new = spmq_pkg::ST_EMPTY;
    end else begin
      take    = 1'b1;
      rd_addr = spmq_pkg::ADDR_W'(sel) * spmq_pkg::ADDR_W'(spmq_pkg::DEPTH)
                + spmq_pkg::ADDR_W'(head[sel]);
      head_next[sel]  = (head[sel] == spmq_pkg::PTR_W'(spmq_pkg::DEPTH - 1)) ?
                        '0 : head[sel] + 1'b1;
      count_next[sel] = count[sel] - 1'b1;
    end
    empty_new = 1'b1;
    for (int k = 0; k < spmq_pkg::LEVELS; k++) begin
      if (count_next[k] != '0) begin
        empty_new = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < spmq_pkg::LEVELS; k++) begin
        head[k]  <= '0;
        tail[k]  <= '0;
        count[k] <= '0;
      end
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= in_ch.item_value;
    end
    if (accept && take) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_new;
      s1_take   <= take;
      s1_empty  <= empty_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status <= s1_status;
      out_value  <= s1_take ? rdata : '0;
      out_empty  <= s1_empty;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.status    = out_status;
  assign out_ch.out_value = out_value;
  assign out_ch.all_empty = out_empty;

endmodule
